// ===== rtl/idec_pkg.sv =====
// Package for the 16-bit instruction decoder: operand form codes, mnemonic bases
// and the per-major tables for the immediate formats.
// No dependencies.
`timescale 1ns / 1ps

package idec_pkg;

    typedef enum logic [3:0] {
        FORM_NONE     = 4'd0,
        FORM_REG      = 4'd1,
        FORM_REG_REG  = 4'd2,
        FORM_REG_IMM  = 4'd3,
        FORM_IMM_REG  = 4'd4,
        FORM_IMM      = 4'd5,
        FORM_XREG_REG = 4'd6,
        FORM_REG_XREG = 4'd7,
        FORM_XREG_IMM = 4'd8
    } t_form;

    typedef logic [6:0] t_op;

    localparam t_op OP_IRT = 7'd0;
    localparam t_op OP_NOP = 7'd2;
    localparam t_op OP_CAL = 7'd6;
    localparam t_op OP_PRF = 7'd10;
    localparam t_op OP_SAA = 7'd12;
    localparam t_op OP_DVU = 7'd20;
    localparam t_op OP_PRD = 7'd22;
    localparam t_op OP_PWR = 7'd23;
    localparam t_op OP_XWR = 7'd25;
    localparam t_op OP_MRD = 7'd26;
    localparam t_op OP_MWR = 7'd27;
    localparam t_op OP_SRD = 7'd28;
    localparam t_op OP_SWR = 7'd29;
    localparam t_op OP_MLU = 7'd30;
    localparam t_op OP_CMP = 7'd31;
    localparam t_op OP_TST = 7'd32;
    localparam t_op OP_MLS = 7'd33;
    localparam t_op OP_MOV = 7'd34;
    localparam t_op OP_CRD = 7'd35;
    localparam t_op OP_CWR = 7'd36;
    localparam t_op OP_SNO = 7'd37;
    localparam t_op OP_ADD = 7'd43;
    localparam t_op OP_INT = 7'd51;
    localparam t_op OP_JAA = 7'd52;
    localparam t_op OP_JMP = 7'd66;
    localparam t_op OP_MAA = 7'd67;
    localparam t_op OP_MNC = 7'd75;

    // Sub-opcode codes under major zero
    localparam logic [4:0] SUB_SYS   = 5'd1;
    localparam logic [4:0] SUB_MISC  = 5'd3;
    localparam logic [4:0] SUB_CACHE = 5'd4;
    localparam logic [4:0] SUB_SET   = 5'd5;
    localparam logic [4:0] SUB_RR_LO = 5'd6;
    localparam logic [4:0] SUB_PWR   = 5'd9;
    localparam logic [4:0] SUB_XRD   = 5'd10;
    localparam logic [4:0] SUB_XWR   = 5'd11;
    localparam logic [4:0] SUB_MWR   = 5'd13;
    localparam logic [4:0] SUB_SWR   = 5'd15;
    localparam logic [4:0] SUB_RR_HI = 5'd22;
    localparam logic [4:0] SUB_SETX  = 5'd23;
    localparam logic [4:0] SUB_ALU   = 5'd24;

    // Major opcodes
    localparam logic [4:0] MAJ_ZERO    = 5'd0;
    localparam logic [4:0] MAJ_IMM8    = 5'd2;
    localparam logic [4:0] MAJ_CACHEI  = 5'd3;
    localparam logic [4:0] MAJ_JCC_LO  = 5'd4;
    localparam logic [4:0] MAJ_JCC_HI  = 5'd5;
    localparam logic [4:0] MAJ_TBL_LO  = 5'd8;
    localparam logic [4:0] MAJ_JMP     = 5'd10;
    localparam logic [4:0] MAJ_CAL     = 5'd21;
    localparam logic [4:0] MAJ_MOVR    = 5'd22;
    localparam logic [4:0] MAJ_MOVX    = 5'd23;
    localparam logic [4:0] MAJ_ALUI    = 5'd24;

    localparam int IMM_TBL_DEPTH = 14;

    localparam t_op IMM_MAJOR_OP [IMM_TBL_DEPTH] = '{
        OP_PRD, OP_PWR, OP_JMP, OP_XWR, OP_MRD, OP_MWR, OP_SRD,
        OP_SWR, OP_MLU, OP_CMP, OP_TST, OP_MLS, OP_MOV, OP_CAL
    };

    localparam t_form IMM_MAJOR_FORM [IMM_TBL_DEPTH] = '{
        FORM_REG_IMM, FORM_IMM_REG, FORM_IMM, FORM_XREG_IMM, FORM_REG_IMM,
        FORM_IMM_REG, FORM_REG_IMM, FORM_IMM_REG, FORM_REG_IMM, FORM_REG_IMM,
        FORM_REG_IMM, FORM_REG_IMM, FORM_REG_IMM, FORM_IMM
    };

endpackage

// ===== rtl/instruction_decoder_16bit.sv =====
// Top level of the 16-bit instruction decoder: input register, decode logic,
// result register. Depends on idec_pkg.
`timescale 1ns / 1ps

// Takes one instruction word per clock cycle; busy is always low. Each result
// passes through the input and result registers to the o_ result ports and holds
// there until the next one, marked by o_strobe high for a single cycle. The receiver
// cannot stall: it must capture every result in the cycle o_strobe is high. The rate
// of one word per cycle is set by the single decode stage between the two registers.
module instruction_decoder_16bit
    import idec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_instruction,
    output logic               o_strobe,
    output logic               o_valid_res,
    output logic [6:0]         o_operation,
    output logic [3:0]         o_operand_form,
    output logic [2:0]         o_first_reg,
    output logic [2:0]         o_second_reg,
    output logic signed [10:0] o_immediate,
    output logic [2:0]         o_ext_reg,
    output logic               o_ext_reg_reserved
);

    logic        r_in_vld;
    logic [15:0] r_instr;

    logic        r_strobe;
    logic        r_valid_res;
    t_op         r_operation;
    t_form       r_form;
    logic [2:0]  r_first_reg;
    logic [2:0]  r_second_reg;
    logic [10:0] r_immediate;
    logic [2:0]  r_ext_reg;
    logic        r_ext_res;

    logic        n_valid_res;
    t_op         n_operation;
    t_form       n_form;
    logic [2:0]  n_first_reg;
    logic [2:0]  n_second_reg;
    logic [10:0] n_immediate;
    logic [2:0]  n_ext_reg;
    logic        n_ext_res;

    logic [4:0]  major;
    logic [4:0]  sub;
    logic [2:0]  rf;
    logic [2:0]  rs;
    logic [3:0]  cond;
    logic [2:0]  tsel;
    logic [4:0]  kfull;
    logic [3:0]  k;
    logic [7:0]  i8l;
    logic [4:0]  i5;
    logic [7:0]  i8;
    logic [10:0] i11;
    logic [10:0] imm_tbl;
    t_form       tbl_form;

    assign busy = 1'b0;

    always_comb begin
        major    = r_instr[15:11];
        sub      = r_instr[4:0];
        rf       = r_instr[7:5];
        rs       = r_instr[10:8];
        cond     = r_instr[11:8];
        tsel     = r_instr[3:1];
        kfull    = major - MAJ_TBL_LO;
        k        = kfull[3:0];
        i8l      = {r_instr[0], r_instr[7:1]};
        i5       = {r_instr[0], r_instr[4:1]};
        i8       = {r_instr[0], r_instr[10:8], r_instr[4:1]};
        i11      = {r_instr[0], r_instr[10:1]};
        imm_tbl  = ((major == MAJ_JMP) || (major == MAJ_CAL)) ? i11
                                                              : {{3{i8[7]}}, i8};
        tbl_form = IMM_MAJOR_FORM[k];
    end

    always_comb begin
        n_valid_res  = 1'b0;
        n_operation  = OP_IRT;
        n_form       = FORM_NONE;
        n_first_reg  = 3'd0;
        n_second_reg = 3'd0;
        n_immediate  = 11'd0;
        n_ext_reg    = 3'd0;
        n_ext_res    = 1'b0;
        if (major == MAJ_ZERO) begin
            if (sub == SUB_SYS) begin
                if (rs < 3'd2) begin
                    n_valid_res = 1'b1;
                    n_operation = OP_IRT + 7'(rs);
                end
            end else if (sub == SUB_MISC) begin
                n_valid_res = 1'b1;
                n_operation = OP_NOP + 7'(rs);
                if (rs != 3'd0 && rs != 3'd5) begin
                    n_form      = FORM_REG;
                    n_first_reg = rf;
                end
            end else if (sub == SUB_CACHE) begin
                if (rs < 3'd2) begin
                    n_valid_res = 1'b1;
                    n_operation = OP_PRF + 7'(rs);
                    n_form      = FORM_REG;
                    n_first_reg = rf;
                end
            end else if (sub == SUB_SET) begin
                n_valid_res = 1'b1;
                n_operation = OP_SAA + 7'(rs);
                n_form      = FORM_REG;
                n_first_reg = rf;
            end else if (sub >= SUB_RR_LO && sub <= SUB_RR_HI) begin
                n_valid_res = 1'b1;
                n_operation = OP_DVU + 7'(sub - SUB_RR_LO);
                if (sub == SUB_XRD) begin
                    n_form      = FORM_REG_XREG;
                    n_first_reg = rf;
                    n_ext_reg   = rs;
                    n_ext_res   = rs[2] | (rs == 3'd1);
                end else if (sub == SUB_XWR) begin
                    n_form      = FORM_XREG_REG;
                    n_first_reg = rs;
                    n_ext_reg   = rf;
                    n_ext_res   = rf[2];
                end else if (sub == SUB_PWR || sub == SUB_MWR || sub == SUB_SWR
                             || sub == SUB_RR_HI) begin
                    n_form       = FORM_REG_REG;
                    n_first_reg  = rs;
                    n_second_reg = rf;
                end else begin
                    n_form       = FORM_REG_REG;
                    n_first_reg  = rf;
                    n_second_reg = rs;
                end
            end else if (sub == SUB_SETX) begin
                if (rs < 3'd6) begin
                    n_valid_res = 1'b1;
                    n_operation = OP_SNO + 7'(rs);
                    n_form      = FORM_REG;
                    n_first_reg = rf;
                end
            end else if (sub >= SUB_ALU) begin
                n_valid_res  = 1'b1;
                n_operation  = OP_ADD + 7'(sub[2:0]);
                n_form       = FORM_REG_REG;
                n_first_reg  = rf;
                n_second_reg = rs;
            end
        end else if (major == MAJ_IMM8) begin
            if (rs == 3'd0) begin
                n_valid_res = 1'b1;
                n_operation = OP_INT;
                n_form      = FORM_IMM;
                n_immediate = {3'd0, i8l};
            end else if (rs == 3'd2 || rs == 3'd3) begin
                n_valid_res = 1'b1;
                n_operation = (rs == 3'd2) ? OP_CRD : OP_CWR;
                n_form      = (rs == 3'd2) ? FORM_REG_IMM : FORM_IMM_REG;
                n_first_reg = rf;
                n_immediate = {{6{i5[4]}}, i5};
            end
        end else if (major == MAJ_CACHEI) begin
            if (rs < 3'd2) begin
                n_valid_res = 1'b1;
                n_operation = OP_PRF + 7'(rs);
                n_form      = FORM_IMM;
                n_immediate = {3'd0, i8l};
            end
        end else if (major == MAJ_JCC_LO || major == MAJ_JCC_HI) begin
            if (cond < 4'd14) begin
                n_valid_res = 1'b1;
                n_operation = OP_JAA + 7'(cond);
                n_form      = FORM_IMM;
                n_immediate = {{3{i8l[7]}}, i8l};
            end
        end else if (major >= MAJ_TBL_LO && major <= MAJ_CAL) begin
            n_valid_res = 1'b1;
            n_operation = IMM_MAJOR_OP[k];
            n_form      = tbl_form;
            n_immediate = imm_tbl;
            if (tbl_form == FORM_XREG_IMM) begin
                n_ext_reg = rf;
                n_ext_res = rf[2];
            end else if (tbl_form != FORM_IMM) begin
                n_first_reg = rf;
            end
        end else if (major == MAJ_MOVR) begin
            n_valid_res  = 1'b1;
            n_operation  = OP_MAA + 7'(tsel);
            n_form       = FORM_REG_REG;
            n_first_reg  = rf;
            n_second_reg = rs;
        end else if (major == MAJ_MOVX) begin
            if (tsel < 3'd6) begin
                n_valid_res  = 1'b1;
                n_operation  = OP_MNC + 7'(tsel);
                n_form       = FORM_REG_REG;
                n_first_reg  = rf;
                n_second_reg = rs;
            end
        end else if (major >= MAJ_ALUI) begin
            n_valid_res = 1'b1;
            n_operation = OP_ADD + 7'(major[2:0]);
            n_form      = FORM_REG_IMM;
            n_first_reg = rf;
            n_immediate = {{3{i8[7]}}, i8};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
            r_strobe <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_instr <= i_instruction;
        end
        if (r_in_vld) begin
            r_valid_res  <= n_valid_res;
            r_operation  <= n_operation;
            r_form       <= n_form;
            r_first_reg  <= n_first_reg;
            r_second_reg <= n_second_reg;
            r_immediate  <= n_immediate;
            r_ext_reg    <= n_ext_reg;
            r_ext_res    <= n_ext_res;
        end
    end

    assign o_strobe           = r_strobe;
    assign o_valid_res        = r_valid_res;
    assign o_operation        = r_operation;
    assign o_operand_form     = r_form;
    assign o_first_reg        = r_first_reg;
    assign o_second_reg       = r_second_reg;
    assign o_immediate        = r_immediate;
    assign o_ext_reg          = r_ext_reg;
    assign o_ext_reg_reserved = r_ext_res;

endmodule
